[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the reorder unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that a condition implies a consequence in the same cycle.
`define GRR_ASSERT_IMPLY(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("implication failed");

// Check that a condition implies a consequence in the next cycle.
`define GRR_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("next-cycle implication failed");

`else

`define GRR_ASSERT_IMPLY(lbl, a, c)
`define GRR_ASSERT_NEXT(lbl, a, c)

`endif

`endif

[rtl/grr_pkg.sv]
// ----------------------------------------------------------------------------
// grr_pkg
// Shared types and constants of the greedy matrix row reorder unit.
// ----------------------------------------------------------------------------
`default_nettype none

package grr_pkg;

    localparam int MAX_SIZE_DEF     = 64;
    localparam int CHANNEL_BITS_DEF = 16;

    localparam int FIELD_CH_W  = 16;
    localparam int FIELD_IDX_W = 6;
    localparam int CFG_SIZE_W  = 7;
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [1:0] {
        OP_WRITE     = 2'd0,
        OP_RUN       = 2'd1,
        OP_READ_ELEM = 2'd2,
        OP_READ_PERM = 2'd3
    } grr_op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MATRIX_SIZE   = 2'd0,
        CFG_DOUBLE_PASS   = 2'd1,
        CFG_KEEP_IDENTITY = 2'd2,
        CFG_UNUSED        = 2'd3
    } grr_cfg_idx_t;

    // Controls of the distance datapath
    typedef struct packed {
        logic load_sq;   // register the squared channel differences
        logic acc;       // add them into the running distance
        logic first;     // first element of a line: restart the sum
    } grr_dist_ctrl_t;

endpackage

`default_nettype wire

[rtl/grr_dist_unit.sv]
// ----------------------------------------------------------------------------
// grr_dist_unit
// Squared-difference distance accumulator over two streamed elements.
// ----------------------------------------------------------------------------
`default_nettype none

module grr_dist_unit
    import grr_pkg::*;
#(
    parameter int MAX_SIZE     = MAX_SIZE_DEF,
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
    localparam int EW = 3 * CHANNEL_BITS,
    localparam int SQ_W = 2 * CHANNEL_BITS,
    localparam int DW = 2 * CHANNEL_BITS + 2 + $clog2(MAX_SIZE)
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire grr_dist_ctrl_t ctrl,
    input  wire logic [EW-1:0]  elem_a,
    input  wire logic [EW-1:0]  elem_b,
    output logic [DW-1:0]       dist_total
);

    logic [SQ_W-1:0] sq_reg   [3];
    logic [SQ_W-1:0] sq_next  [3];
    logic [DW-1:0]   dist_reg;
    logic [DW-1:0]   dist_next;
    logic [DW-1:0]   sq_sum;

    always_comb
    begin
        logic [CHANNEL_BITS-1:0] a;
        logic [CHANNEL_BITS-1:0] b;
        logic [CHANNEL_BITS-1:0] d;
        for (int ch = 0; ch < 3; ch++)
        begin
            a = elem_a[ch*CHANNEL_BITS +: CHANNEL_BITS];
            b = elem_b[ch*CHANNEL_BITS +: CHANNEL_BITS];
            d = (a > b) ? (a - b) : (b - a);
            sq_next[ch] = SQ_W'(d) * SQ_W'(d);
        end
    end

    assign sq_sum = DW'(sq_reg[0]) + DW'(sq_reg[1]) + DW'(sq_reg[2]);

    always_comb
    begin
        dist_next = dist_reg;
        if (ctrl.acc)
        begin
            dist_next = ctrl.first ? sq_sum : (dist_reg + sq_sum);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_sq)
        begin
            sq_reg <= sq_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_reg <= '0;
        end
        else
        begin
            dist_reg <= dist_next;
        end
    end

    assign dist_total = dist_reg;

endmodule

`default_nettype wire

[rtl/greedy_matrix_row_reorder_unit.sv]
// ----------------------------------------------------------------------------
// greedy_matrix_row_reorder_unit
// Matrix store with a greedy row/column reordering sequencer.
// ----------------------------------------------------------------------------
// The unit holds a square matrix of three-channel elements in one on-chip
// memory with a write port and two registered read ports, and a permutation
// in a small memory whose entries read as their own index until written
// after a run starts. Items arrive on the slave stream with the operation in
// tuser; each item gives exactly one result item on the master stream.
// Element writes, bad-index items and permutation-free results are answered
// in the cycle after acceptance; element and permutation reads pass through
// the S_RWAIT state for the memory read, so back-to-back loads go at one item
// per cycle while the master stream does not stall, and a read takes no new
// item until it is answered. A run walks the matrix: every candidate line is
// read, squared and accumulated per element, then compared once, and every
// swap reads and writes the two permutation entries, then reads, writes and
// writes each of the 2*n elements moved. One pass steps the position i from 1
// to n-2 and tries candidates i to n-1 at each; swaps move their elements
// through the single write port. The unit takes no new item while a run is in
// progress. Configuration writes are taken at any cycle and must only come
// while the unit is idle.
`default_nettype none

module greedy_matrix_row_reorder_unit
    import grr_pkg::*;
#(
    parameter int MAX_SIZE     = MAX_SIZE_DEF,
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // Slave stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [63:0]          s_tdata,   // row, col, elem_red, elem_green, elem_blue
    input  wire logic [1:0]           s_tuser,   // operation
    // Master stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [55:0]               m_tdata,   // out_red, out_green, out_blue,
                                                 // order_entry, status
    // Configuration writes
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_SIZE_W-1:0] cfg_data
);

    localparam int IW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int NW    = $clog2(MAX_SIZE + 1);
    localparam int CW    = (NW > CFG_SIZE_W) ? NW : CFG_SIZE_W;
    localparam int DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = 3 * CHANNEL_BITS;
    localparam int DW    = 2 * CHANNEL_BITS + 2 + $clog2(MAX_SIZE);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_RWAIT = 13'b0000000000010,
        S_DRD   = 13'b0000000000100,
        S_DSQ   = 13'b0000000001000,
        S_DACC  = 13'b0000000010000,
        S_CMP   = 13'b0000000100000,
        S_PRD   = 13'b0000001000000,
        S_PWA   = 13'b0000010000000,
        S_PWB   = 13'b0000100000000,
        S_SRD   = 13'b0001000000000,
        S_SWA   = 13'b0010000000000,
        S_SWB   = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } grr_state_t;

    // ---------------- configuration registers ----------------
    logic [CFG_SIZE_W-1:0] size_cfg_reg;
    logic                  double_reg;
    logic                  keep_id_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_cfg_reg <= CFG_SIZE_W'(64);
            double_reg   <= 1'b0;
            keep_id_reg  <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (grr_cfg_idx_t'(cfg_index))
                CFG_MATRIX_SIZE:   size_cfg_reg <= cfg_data;
                CFG_DOUBLE_PASS:   double_reg   <= cfg_data[0];
                CFG_KEEP_IDENTITY: keep_id_reg  <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Size in use: zero acts as one, clamp to the store
    logic [CW-1:0] size_ext;
    logic [NW-1:0] n;
    assign size_ext = CW'(size_cfg_reg);

    always_comb
    begin
        if (size_ext == '0)
        begin
            n = NW'(1);
        end
        else if (size_ext > CW'(MAX_SIZE))
        begin
            n = NW'(MAX_SIZE);
        end
        else
        begin
            n = NW'(size_ext);
        end
    end

    // ---------------- input unpacking ----------------
    grr_op_t                 in_op;
    logic [FIELD_IDX_W-1:0]  in_row;
    logic [FIELD_IDX_W-1:0]  in_col;
    logic [EW-1:0]           in_elem;

    assign in_op   = grr_op_t'(s_tuser);
    assign in_row  = s_tdata[5:0];
    assign in_col  = s_tdata[11:6];
    assign in_elem = {CHANNEL_BITS'(s_tdata[59:44]), CHANNEL_BITS'(s_tdata[43:28]),
                      CHANNEL_BITS'(s_tdata[27:12])};

    logic row_bad;
    logic col_bad;
    assign row_bad = (CW'(in_row) >= CW'(n));
    assign col_bad = (CW'(in_col) >= CW'(n));

    function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] r,
                                                 input logic [IW-1:0] c);
        cell_addr = AW'(r) * AW'(MAX_SIZE) + AW'(c);
    endfunction

    // ---------------- sequencer registers ----------------
    grr_state_t     state_reg, state_next;
    logic [NW-1:0]  i_reg, i_next;
    logic [NW-1:0]  j_reg, j_next;
    logic [NW-1:0]  k_reg, k_next;
    logic           pass_col_reg, pass_col_next;
    logic           swap_col_reg, swap_col_next;
    logic           rd_perm_reg, rd_perm_next;
    logic [DW-1:0]  best_dist_reg, best_dist_next;
    logic [IW-1:0]  best_idx_reg, best_idx_next;

    logic           out_valid_reg, out_valid_next;
    logic [55:0]    out_data_reg, out_data_next;

    logic           accept;
    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ---------------- matrix memory ----------------
    logic [EW-1:0] mat_mem [DEPTH];
    logic          mat_we;
    logic [AW-1:0] mat_waddr;
    logic [EW-1:0] mat_wdata;
    logic          mat_re;
    logic [AW-1:0] mat_raddr_a, mat_raddr_b;
    logic [EW-1:0] mat_q_a, mat_q_b;

    always_ff @(posedge clk)
    begin
        if (mat_we)
        begin
            mat_mem[mat_waddr] <= mat_wdata;
        end
        if (mat_re)
        begin
            mat_q_a <= mat_mem[mat_raddr_a];
            mat_q_b <= mat_mem[mat_raddr_b];
        end
    end

    // ---------------- permutation memory ----------------
    logic [IW-1:0]       perm_mem [MAX_SIZE];
    logic [MAX_SIZE-1:0] perm_vld_reg;
    logic                perm_clear;
    logic                perm_we;
    logic [IW-1:0]       perm_waddr, perm_wdata;
    logic                perm_re;
    logic [IW-1:0]       perm_raddr_a, perm_raddr_b;
    logic [IW-1:0]       perm_mq_a, perm_mq_b;
    logic [IW-1:0]       perm_ix_a, perm_ix_b;
    logic                perm_v_a, perm_v_b;
    logic [IW-1:0]       perm_val_a, perm_val_b;

    always_ff @(posedge clk)
    begin
        if (perm_we)
        begin
            perm_mem[perm_waddr] <= perm_wdata;
        end
        if (perm_re)
        begin
            perm_mq_a <= perm_mem[perm_raddr_a];
            perm_mq_b <= perm_mem[perm_raddr_b];
            perm_ix_a <= perm_raddr_a;
            perm_ix_b <= perm_raddr_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            perm_vld_reg <= '0;
            perm_v_a     <= 1'b0;
            perm_v_b     <= 1'b0;
        end
        else
        begin
            if (perm_re)
            begin
                perm_v_a <= perm_vld_reg[perm_raddr_a];
                perm_v_b <= perm_vld_reg[perm_raddr_b];
            end
            if (perm_clear)
            begin
                perm_vld_reg <= '0;
            end
            else if (perm_we)
            begin
                perm_vld_reg[perm_waddr] <= 1'b1;
            end
        end
    end

    // Unwritten entries read as their own position
    assign perm_val_a = perm_v_a ? perm_mq_a : perm_ix_a;
    assign perm_val_b = perm_v_b ? perm_mq_b : perm_ix_b;

    // ---------------- distance datapath ----------------
    grr_dist_ctrl_t dctrl;
    logic [DW-1:0]  cand_dist;

    assign dctrl.load_sq = (state_reg == S_DSQ);
    assign dctrl.acc     = (state_reg == S_DACC);
    assign dctrl.first   = (k_reg == '0);

    grr_dist_unit #(
        .MAX_SIZE     (MAX_SIZE),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_dist (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (dctrl),
        .elem_a     (mat_q_a),
        .elem_b     (mat_q_b),
        .dist_total (cand_dist)
    );

    // ---------------- sequencer ----------------
    logic [IW-1:0] i_ix, ip_ix, j_ix, k_ix;
    logic          cand_better;
    logic [IW-1:0] win_idx;

    assign i_ix  = i_reg[IW-1:0];
    assign ip_ix = IW'(i_reg - NW'(1));
    assign j_ix  = j_reg[IW-1:0];
    assign k_ix  = k_reg[IW-1:0];

    assign cand_better = (j_reg == i_reg) || (cand_dist < best_dist_reg);
    assign win_idx     = cand_better ? j_ix : best_idx_reg;

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        pass_col_next  = pass_col_reg;
        swap_col_next  = swap_col_reg;
        rd_perm_next   = rd_perm_reg;
        best_dist_next = best_dist_reg;
        best_idx_next  = best_idx_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;

        mat_we       = 1'b0;
        mat_waddr    = cell_addr(i_ix, k_ix);
        mat_wdata    = mat_q_b;
        mat_re       = 1'b0;
        mat_raddr_a  = cell_addr(IW'(in_row), IW'(in_col));
        mat_raddr_b  = mat_raddr_a;
        perm_clear   = 1'b0;
        perm_we      = 1'b0;
        perm_waddr   = i_ix;
        perm_wdata   = perm_val_b;
        perm_re      = 1'b0;
        perm_raddr_a = IW'(in_row);
        perm_raddr_b = perm_raddr_a;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_data_next = '0;
                    case (in_op)
                        OP_WRITE:
                        begin
                            out_valid_next    = 1'b1;
                            out_data_next[54] = row_bad || col_bad;
                            mat_waddr         = cell_addr(IW'(in_row), IW'(in_col));
                            mat_wdata         = in_elem;
                            mat_we            = !(row_bad || col_bad);
                        end
                        OP_READ_ELEM:
                        begin
                            if (row_bad || col_bad)
                            begin
                                out_valid_next    = 1'b1;
                                out_data_next[54] = 1'b1;
                            end
                            else
                            begin
                                mat_re       = 1'b1;
                                rd_perm_next = 1'b0;
                                state_next   = S_RWAIT;
                            end
                        end
                        OP_READ_PERM:
                        begin
                            if (row_bad)
                            begin
                                out_valid_next    = 1'b1;
                                out_data_next[54] = 1'b1;
                            end
                            else
                            begin
                                perm_re      = 1'b1;
                                rd_perm_next = 1'b1;
                                state_next   = S_RWAIT;
                            end
                        end
                        default:
                        begin
                            // Run: restart from the identity order
                            perm_clear = 1'b1;
                            if (keep_id_reg || (n < NW'(3)))
                            begin
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                i_next        = NW'(1);
                                j_next        = NW'(1);
                                k_next        = '0;
                                pass_col_next = 1'b0;
                                state_next    = S_DRD;
                            end
                        end
                    endcase
                end
            end

            S_RWAIT:
            begin
                out_valid_next = 1'b1;
                out_data_next  = '0;
                if (rd_perm_reg)
                begin
                    out_data_next[53:48] = FIELD_IDX_W'(perm_val_a);
                end
                else
                begin
                    out_data_next[15:0]  = FIELD_CH_W'(mat_q_a[0 +: CHANNEL_BITS]);
                    out_data_next[31:16] = FIELD_CH_W'(mat_q_a[CHANNEL_BITS +: CHANNEL_BITS]);
                    out_data_next[47:32] =
                        FIELD_CH_W'(mat_q_a[2*CHANNEL_BITS +: CHANNEL_BITS]);
                end
                state_next = S_IDLE;
            end

            S_DRD:
            begin
                // Fetch element k of the previous line and the candidate line
                mat_re = 1'b1;
                if (pass_col_reg)
                begin
                    mat_raddr_a = cell_addr(k_ix, ip_ix);
                    mat_raddr_b = cell_addr(k_ix, j_ix);
                end
                else
                begin
                    mat_raddr_a = cell_addr(ip_ix, k_ix);
                    mat_raddr_b = cell_addr(j_ix, k_ix);
                end
                state_next = S_DSQ;
            end

            S_DSQ:
            begin
                state_next = S_DACC;
            end

            S_DACC:
            begin
                if ((k_reg + NW'(1)) < n)
                begin
                    k_next     = k_reg + NW'(1);
                    state_next = S_DRD;
                end
                else
                begin
                    state_next = S_CMP;
                end
            end

            S_CMP:
            begin
                if (cand_better)
                begin
                    best_dist_next = cand_dist;
                    best_idx_next  = j_ix;
                end
                k_next = '0;
                if ((j_reg + NW'(1)) < n)
                begin
                    j_next     = j_reg + NW'(1);
                    state_next = S_DRD;
                end
                else if (win_idx != i_ix)
                begin
                    state_next = S_PRD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_PRD:
            begin
                perm_re      = 1'b1;
                perm_raddr_a = i_ix;
                perm_raddr_b = best_idx_reg;
                state_next   = S_PWA;
            end

            S_PWA:
            begin
                perm_we    = 1'b1;
                perm_waddr = i_ix;
                perm_wdata = perm_val_b;
                state_next = S_PWB;
            end

            S_PWB:
            begin
                perm_we       = 1'b1;
                perm_waddr    = best_idx_reg;
                perm_wdata    = perm_val_a;
                k_next        = '0;
                swap_col_next = 1'b0;
                state_next    = S_SRD;
            end

            S_SRD:
            begin
                mat_re = 1'b1;
                if (swap_col_reg)
                begin
                    mat_raddr_a = cell_addr(k_ix, i_ix);
                    mat_raddr_b = cell_addr(k_ix, best_idx_reg);
                end
                else
                begin
                    mat_raddr_a = cell_addr(i_ix, k_ix);
                    mat_raddr_b = cell_addr(best_idx_reg, k_ix);
                end
                state_next = S_SWA;
            end

            S_SWA:
            begin
                mat_we     = 1'b1;
                mat_waddr  = swap_col_reg ? cell_addr(k_ix, i_ix) : cell_addr(i_ix, k_ix);
                mat_wdata  = mat_q_b;
                state_next = S_SWB;
            end

            S_SWB:
            begin
                mat_we    = 1'b1;
                mat_waddr = swap_col_reg ? cell_addr(k_ix, best_idx_reg)
                                         : cell_addr(best_idx_reg, k_ix);
                mat_wdata = mat_q_a;
                if ((k_reg + NW'(1)) < n)
                begin
                    k_next     = k_reg + NW'(1);
                    state_next = S_SRD;
                end
                else if (!swap_col_reg)
                begin
                    swap_col_next = 1'b1;
                    k_next        = '0;
                    state_next    = S_SRD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                // Advance to the next position, the next pass, or finish
                k_next = '0;
                if ((i_reg + NW'(2)) < n)
                begin
                    i_next     = i_reg + NW'(1);
                    j_next     = i_reg + NW'(1);
                    state_next = S_DRD;
                end
                else if (!pass_col_reg && double_reg)
                begin
                    pass_col_next = 1'b1;
                    i_next        = NW'(1);
                    j_next        = NW'(1);
                    state_next    = S_DRD;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            pass_col_reg  <= 1'b0;
            swap_col_reg  <= 1'b0;
            rd_perm_reg   <= 1'b0;
            best_dist_reg <= '0;
            best_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            pass_col_reg  <= pass_col_next;
            swap_col_reg  <= swap_col_next;
            rd_perm_reg   <= rd_perm_next;
            best_dist_reg <= best_dist_next;
            best_idx_reg  <= best_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    // ---------------- assertions ----------------
`include "assert_macros.svh"

    `GRR_ASSERT_IMPLY(a_busy_not_ready, state_reg != S_IDLE, !s_tready)
    `GRR_ASSERT_IMPLY(a_best_in_range, state_reg == S_PRD, best_idx_reg > i_ix)
    `GRR_ASSERT_IMPLY(a_swap_writes_only, mat_we && (state_reg != S_IDLE),
        (state_reg == S_SWA) || (state_reg == S_SWB))
    `GRR_ASSERT_NEXT(a_read_answers, state_reg == S_RWAIT, out_valid_reg)

endmodule

`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the greedy matrix row reorder unit.
// ----------------------------------------------------------------------------
// Loads matrices over the slave stream, starts greedy runs under several
// size, double-pass and bypass settings, and reads elements and permutation
// entries back. A behavioral copy of the unit computes each expected result
// item at acceptance. A monitor compares every master-stream item with the
// oldest expected one. The sender pauses in bursts and the receiver stalls
// in modes of its own.
// ----------------------------------------------------------------------------
`default_nettype none

module tb
    import grr_pkg::*;
();

    localparam int DIM = 64;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } pixel_t;

    // Highest field first: status sits in bit 54 of the result item, below the unused top bit
    typedef struct packed {
        logic        status;
        logic [5:0]  order;
        logic [15:0] blue;
        logic [15:0] green;
        logic [15:0] red;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_SIZE_W-1:0] cfg_data;

    greedy_matrix_row_reorder_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow of the unit: matrix, permutation and registers
    pixel_t      shadow_mat [DIM*DIM];
    bit          cell_loaded [DIM*DIM];
    logic [5:0]  shadow_perm [DIM];
    logic [6:0]  size_reg;
    bit          dbl_reg;
    bit          bypass_reg;

    answer_t     pending_answers [$];

    int mismatches;
    int n_checked;
    int n_runs;
    int n_reads;
    int n_writes;
    int n_phases;
    int burst_left;
    bit gaps_on;
    int stall_mode;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop: far beyond the slowest legal run
    initial
    begin
        #40_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic int eff_size();
        if (size_reg == 7'd0)
            return 1;
        if (size_reg > DIM)
            return DIM;
        return int'(size_reg);
    endfunction

    function automatic int addr(int r, int c);
        return r * DIM + c;
    endfunction

    function automatic longint unsigned pixel_dist(int p, int q);
        longint unsigned total;
        longint unsigned d;
        total = 0;
        d = (shadow_mat[p].red > shadow_mat[q].red) ?
            shadow_mat[p].red - shadow_mat[q].red : shadow_mat[q].red - shadow_mat[p].red;
        total += d * d;
        d = (shadow_mat[p].green > shadow_mat[q].green) ?
            shadow_mat[p].green - shadow_mat[q].green :
            shadow_mat[q].green - shadow_mat[p].green;
        total += d * d;
        d = (shadow_mat[p].blue > shadow_mat[q].blue) ?
            shadow_mat[p].blue - shadow_mat[q].blue : shadow_mat[q].blue - shadow_mat[p].blue;
        total += d * d;
        return total;
    endfunction

    // Distance of two rows (or two columns) over the used part
    function automatic longint unsigned line_dist(int a, int b, int n, bit by_col);
        longint unsigned total;
        total = 0;
        for (int k = 0; k < n; k++)
        begin
            if (by_col)
                total += pixel_dist(addr(k, a), addr(k, b));
            else
                total += pixel_dist(addr(a, k), addr(b, k));
        end
        return total;
    endfunction

    function automatic void greedy_order(int n, bit by_col);
        longint unsigned best;
        longint unsigned d;
        int     pick;
        pixel_t t;
        logic [5:0] e;
        for (int i = 1; i + 1 < n; i++)
        begin
            best = line_dist(i - 1, i, n, by_col);
            pick = i;
            for (int j = i + 1; j < n; j++)
            begin
                d = line_dist(i - 1, j, n, by_col);
                // strict compare: first minimum wins a tie
                if (d < best)
                begin
                    best = d;
                    pick = j;
                end
            end
            if (pick != i)
            begin
                e = shadow_perm[i];
                shadow_perm[i] = shadow_perm[pick];
                shadow_perm[pick] = e;
                for (int k = 0; k < n; k++)
                begin
                    t = shadow_mat[addr(i, k)];
                    shadow_mat[addr(i, k)] = shadow_mat[addr(pick, k)];
                    shadow_mat[addr(pick, k)] = t;
                end
                for (int k = 0; k < n; k++)
                begin
                    t = shadow_mat[addr(k, i)];
                    shadow_mat[addr(k, i)] = shadow_mat[addr(k, pick)];
                    shadow_mat[addr(k, pick)] = t;
                end
            end
        end
    endfunction

    // Expected result item for one accepted input item
    function automatic answer_t reorder_answer(grr_op_t op, int r, int c, pixel_t px);
        answer_t a;
        int      n;
        a = '0;
        n = eff_size();
        case (op)
            OP_WRITE:
            begin
                if (r >= n || c >= n)
                    a.status = 1'b1;
                else
                begin
                    shadow_mat[addr(r, c)] = px;
                    cell_loaded[addr(r, c)] = 1'b1;
                end
            end
            OP_RUN:
            begin
                for (int i = 0; i < DIM; i++)
                    shadow_perm[i] = 6'(i);
                if (!bypass_reg)
                begin
                    greedy_order(n, 1'b0);
                    if (dbl_reg)
                        greedy_order(n, 1'b1);
                end
            end
            OP_READ_ELEM:
            begin
                if (r >= n || c >= n)
                    a.status = 1'b1;
                else
                begin
                    a.red   = shadow_mat[addr(r, c)].red;
                    a.green = shadow_mat[addr(r, c)].green;
                    a.blue  = shadow_mat[addr(r, c)].blue;
                end
            end
            default:
            begin
                if (r >= n)
                    a.status = 1'b1;
                else
                    a.order = shadow_perm[r];
            end
        endcase
        return a;
    endfunction

    // Send one item on the slave stream; valid stays high for the next one
    task automatic send_item(grr_op_t op, int r, int c, pixel_t px);
        int gap;
        if (burst_left == 0)
        begin
            if (gaps_on)
            begin
                gap = $urandom_range(0, 6);
                if (gap != 0)
                begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'd0, px.blue, px.green, px.red, 6'(c), 6'(r)};
        do
            @(posedge clk);
        while (!s_tready);
        pending_answers = {pending_answers, reorder_answer(op, r, c, px)};
        case (op)
            OP_WRITE:     n_writes++;
            OP_RUN:       n_runs++;
            default:      n_reads++;
        endcase
    endtask

    // Drop valid and let every expected item come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    task automatic write_reg(grr_cfg_idx_t idx, logic [6:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_MATRIX_SIZE:   size_reg = val;
            CFG_DOUBLE_PASS:   dbl_reg = val[0];
            CFG_KEEP_IDENTITY: bypass_reg = val[0];
            default:           ;
        endcase
    endtask

    function automatic pixel_t rand_pixel(bit tie_prone);
        pixel_t px;
        if (tie_prone)
        begin
            // few distinct values so distances often tie
            px.red   = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
            px.green = 16'($urandom_range(0, 1));
            px.blue  = 16'h0000;
        end
        else
        begin
            px.red   = 16'($urandom);
            px.green = 16'($urandom);
            px.blue  = 16'($urandom);
        end
        return px;
    endfunction

    // Load every used element, as a run may only walk loaded elements
    task automatic fill_matrix(bit tie_prone);
        int n;
        n = eff_size();
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                send_item(OP_WRITE, r, c, rand_pixel(tie_prone));
    endtask

    // ---------------------------------------------------------------- tests

    // Default size 64: corner elements, channel extremes, identity order
    task automatic test_reset_defaults();
        send_item(OP_WRITE, 63, 63, '{16'hFFFF, 16'hFFFF, 16'hFFFF});
        send_item(OP_WRITE, 0, 0, '{16'h0000, 16'h0000, 16'h0000});
        send_item(OP_READ_ELEM, 63, 63, '0);
        send_item(OP_READ_ELEM, 0, 0, '0);
        send_item(OP_READ_PERM, 63, 0, '0);
        wait_idle();
    endtask

    // Size 0 acts as 1, size 127 as 64; indices past the size flag status
    task automatic test_size_limits();
        write_reg(CFG_MATRIX_SIZE, 7'd0);
        send_item(OP_WRITE, 0, 1, '{16'h1234, 16'h5678, 16'h9ABC});
        send_item(OP_READ_ELEM, 1, 0, '0);
        send_item(OP_READ_PERM, 1, 0, '0);
        wait_idle();
        write_reg(CFG_MATRIX_SIZE, 7'd127);
        send_item(OP_WRITE, 63, 0, '{16'hA5A5, 16'h5A5A, 16'h00FF});
        send_item(OP_READ_ELEM, 63, 0, '0);
        wait_idle();
    endtask

    // Small run with both passes, then the same run in bypass
    task automatic test_directed_runs();
        write_reg(CFG_MATRIX_SIZE, 7'd3);
        write_reg(CFG_DOUBLE_PASS, 7'd1);
        write_reg(CFG_KEEP_IDENTITY, 7'd0);
        wait_idle();
        fill_matrix(1'b0);
        send_item(OP_RUN, 0, 0, '0);
        for (int i = 0; i < 3; i++)
            send_item(OP_READ_PERM, i, 0, '0);
        send_item(OP_READ_ELEM, 1, 2, '0);
        wait_idle();
        write_reg(CFG_KEEP_IDENTITY, 7'd1);
        write_reg(CFG_UNUSED, 7'h7F);
        wait_idle();
        send_item(OP_RUN, 0, 0, '0);
        send_item(OP_READ_PERM, 2, 0, '0);
        wait_idle();
    endtask

    // Random phases: new settings, full load, then a mix of operations
    task automatic test_random_phases();
        int  n;
        int  items;
        int  k;
        int  r;
        int  c;
        int  pick;
        bit  big_done;
        items = 0;
        big_done = 1'b0;
        while (items < 500)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                n = $urandom_range(1, 2);
            else if (pick == 1 && !big_done)
            begin
                n = 16;
                big_done = 1'b1;
            end
            else
                n = $urandom_range(3, 9);
            write_reg(CFG_MATRIX_SIZE, 7'(n));
            write_reg(CFG_DOUBLE_PASS, 7'($urandom_range(0, 1)));
            write_reg(CFG_KEEP_IDENTITY, ($urandom_range(0, 4) == 0) ? 7'd1 : 7'd0);
            if ($urandom_range(0, 5) == 0)
                write_reg(CFG_UNUSED, 7'($urandom));
            gaps_on = ($urandom_range(0, 3) != 0);
            n_phases++;
            wait_idle();
            fill_matrix($urandom_range(0, 2) == 0);
            items += n * n;
            k = $urandom_range(10, 30);
            for (int i = 0; i < k; i++)
            begin
                pick = $urandom_range(0, 9);
                r = $urandom_range(0, 63);
                c = $urandom_range(0, 63);
                if (pick < 2)
                    send_item(OP_RUN, r, c, rand_pixel(1'b0));
                else if (pick < 4)
                    send_item(OP_WRITE, $urandom_range(0, n - 1),
                              $urandom_range(0, n - 1), rand_pixel(1'b0));
                else if (pick == 4)
                    // any index: out-of-range writes must be dropped
                    send_item(OP_WRITE, r, c, rand_pixel(1'b0));
                else if (pick < 7)
                    send_item(OP_READ_PERM, ($urandom_range(0, 3) == 0) ? r :
                              $urandom_range(0, n - 1), c, rand_pixel(1'b0));
                else if (r >= n || c >= n || cell_loaded[addr(r, c)])
                    send_item(OP_READ_ELEM, r, c, rand_pixel(1'b0));
                else
                    send_item(OP_READ_ELEM, $urandom_range(0, n - 1),
                              $urandom_range(0, n - 1), rand_pixel(1'b0));
            end
            items += k;
            wait_idle();
        end
    endtask

    // ------------------------------------------------------- result checker
    always @(posedge clk)
    begin
        answer_t got;
        answer_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = answer_t'(m_tdata[54:0]);
            if (pending_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result item %h", m_tdata);
            end
            else
            begin
                want = pending_answers.pop_front();
                n_checked++;
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue || got.order !== want.order ||
                    got.status !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: item %0d exp %h/%h/%h o=%0d s=%b got %h/%h/%h o=%0d s=%b",
                                 n_checked, want.red, want.green, want.blue,
                                 want.order, want.status, got.red, got.green,
                                 got.blue, got.order, got.status);
                end
            end
        end
    end

    // Receiver: switch between always-ready, random and long-stall modes
    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 9) < 7);
            default: m_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // ------------------------------------------------------------ sequence
    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = OP_WRITE;
        m_tready   = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_MATRIX_SIZE;
        cfg_data   = '0;
        stall_mode = 0;
        mismatches = 0;
        n_checked  = 0;
        n_runs     = 0;
        n_reads    = 0;
        n_writes   = 0;
        n_phases   = 0;
        burst_left = 0;
        gaps_on    = 1'b1;
        size_reg   = 7'd64;
        dbl_reg    = 1'b0;
        bypass_reg = 1'b0;
        for (int i = 0; i < DIM; i++)
            shadow_perm[i] = 6'(i);
        for (int i = 0; i < DIM * DIM; i++)
        begin
            shadow_mat[i]  = '0;
            cell_loaded[i] = 1'b0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_size_limits();
        test_directed_runs();
        test_random_phases();

        wait_idle();
        repeat (20) @(posedge clk);
        $display("Checked %0d result items: %0d loads, %0d reads, %0d runs in %0d phases.",
                 n_checked, n_writes, n_reads, n_runs, n_phases);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
+incdir+rtl
rtl/grr_pkg.sv
rtl/grr_dist_unit.sv
rtl/greedy_matrix_row_reorder_unit.sv
tb/sv/tb.sv
